FILE: rtl/chip8_instruction_executor_defines.svh
`ifndef CHIP8_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_DEFINES_SVH

// same-cycle implication on clk, off during reset
`define C8IE_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, off during reset
`define C8IE_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/c8ie_pkg.sv
`default_nettype none

package c8ie_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int STACK_DEPTH = 16;

    localparam int MEM_AW  = $clog2(MEM_BYTES);
    localparam int PIXELS  = SCREEN_W * SCREEN_H;
    localparam int PIX_AW  = $clog2(PIXELS);
    localparam int COL_W   = $clog2(SCREEN_W);
    localparam int ROW_W   = $clog2(SCREEN_H);
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);

    localparam logic [11:0] FONT_BASE  = 12'h050;
    localparam int          FONT_BYTES = 80;
    localparam logic [11:0] PC_RESET   = 12'h200;
    localparam logic [7:0]  TICK_RESET = 8'd16;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;
    localparam logic [7:0]  KK_SKP  = 8'h9E;
    localparam logic [7:0]  KK_SKNP = 8'hA1;
    localparam logic [7:0]  KK_GDLY = 8'h07;
    localparam logic [7:0]  KK_WKEY = 8'h0A;
    localparam logic [7:0]  KK_SDLY = 8'h15;
    localparam logic [7:0]  KK_SSND = 8'h18;
    localparam logic [7:0]  KK_ADDI = 8'h1E;
    localparam logic [7:0]  KK_FONT = 8'h29;
    localparam logic [7:0]  KK_BCD  = 8'h33;
    localparam logic [7:0]  KK_STOR = 8'h55;
    localparam logic [7:0]  KK_LOAD = 8'h65;

    typedef enum logic [1:0] {
        FUNC_EXEC = 2'd0,
        FUNC_WMEM = 2'd1,
        FUNC_TIME = 2'd2,
        FUNC_PIX  = 2'd3
    } func_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_RDX,
        S_RDY,
        S_EXEC,
        S_TICK,
        S_PIX,
        S_CLS,
        S_BCD,
        S_STORE,
        S_LOAD_RD,
        S_LOAD_WR,
        S_DRW_MRD,
        S_DRW_MCAP,
        S_DRW_PRD,
        S_DRW_PWR,
        S_DONE
    } state_t;

    localparam logic [7:0] GLYPHS [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    function automatic logic [7:0] mem_init_byte(input logic [11:0] a);
        logic [11:0] off;
        off = a - FONT_BASE;
        if (a >= FONT_BASE && off < 12'(FONT_BYTES))
        begin
            return GLYPHS[off[6:0]];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [13:0] hp;
        logic [1:0]  h;
        logic [7:0]  r;
        logic [14:0] tp;
        logic [3:0]  t;
        logic [7:0]  o;
        hp = 14'(v) * 14'd41;
        h  = hp[13:12];
        r  = v - 8'(h) * 8'd100;
        tp = 15'(r) * 15'd205;
        t  = tp[14:11];
        o  = r - 8'(t) * 8'd10;
        if (sel == 2'd0)
        begin
            return 8'(h);
        end
        else if (sel == 2'd1)
        begin
            return 8'(t);
        end
        return o;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/c8ie_ram.sv
`default_nettype none

module c8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/chip8_instruction_executor.sv
`default_nettype none

// CHIP-8 executor: one item per beat in, one result per item out, one item at a time.
// After reset a clearing pass over all 4096 addresses loads the font into data memory and
// blanks the screen; no item is taken until it ends. Most items pass through S_RDX, S_RDY,
// S_EXEC and S_DONE from accept to result. Work is bound by the data memory and frame
// buffer, each with one write and one read port: 00E0 writes all 2048 pixels in turn, DXYN
// reads each sprite row and visits each of its pixels, writing back the set ones, FX33
// writes three digits, FX55 and FX65 move X+1 bytes, and a time step goes tick by tick.

`include "chip8_instruction_executor_defines.svh"

module chip8_instruction_executor (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        func,
    input  wire logic [15:0]       opcode,
    input  wire logic [15:0]       key_state,
    input  wire logic [7:0]        random_byte,
    input  wire logic [11:0]       mem_addr,
    input  wire logic [7:0]        mem_data,
    input  wire logic [9:0]        elapsed_ms,
    input  wire logic [10:0]       pixel_index,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [11:0]            next_pc,
    output logic [15:0]            index_value,
    output logic [7:0]             flag_value,
    output logic [7:0]             delay_value,
    output logic                   sound_on,
    output logic signed [4:0]      key_wait_reg,
    output logic                   pixel_value
);

    import c8ie_pkg::*;

    state_t state_reg, state_next;

    logic        out_valid_reg, out_valid_next;
    logic [11:0] o_pc_reg, o_pc_next;
    logic [15:0] o_idx_reg, o_idx_next;
    logic [7:0]  o_flag_reg, o_flag_next;
    logic [7:0]  o_dly_reg, o_dly_next;
    logic        o_snd_reg, o_snd_next;
    logic [4:0]  o_wait_reg, o_wait_next;
    logic        o_pix_reg, o_pix_next;

    logic [1:0]  func_reg, func_next;
    logic [15:0] op_reg, op_next;
    logic [15:0] keys_reg, keys_next;
    logic [7:0]  rnd_reg, rnd_next;
    logic [11:0] maddr_reg, maddr_next;
    logic [7:0]  mdata_reg, mdata_next;
    logic [9:0]  elapsed_reg, elapsed_next;
    logic [10:0] pidx_reg, pidx_next;

    logic [7:0]  vx_reg, vx_next;
    logic [7:0]  vy_reg, vy_next;
    logic [11:0] pc_reg, pc_next;
    logic [15:0] index_reg, index_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [7:0]  delay_reg, delay_next;
    logic [7:0]  sound_reg, sound_next;
    logic [4:0]  wait_reg, wait_next;
    logic [15:0] accum_reg, accum_next;
    logic [7:0]  tick_reg;
    logic [11:0] cnt_reg, cnt_next;
    logic [2:0]  p_reg, p_next;
    logic [7:0]  bits_reg, bits_next;
    logic        coll_reg, coll_next;
    logic        pix_reg, pix_next;

    logic [7:0]  gp_regs [16];
    logic [11:0] stack_mem [STACK_DEPTH+1];

    logic        gp_we;
    logic [3:0]  gp_waddr;
    logic [7:0]  gp_wdata;
    logic        vf_we;
    logic [7:0]  vf_wdata;
    logic [3:0]  rd_sel;
    logic [7:0]  gp_rd;
    logic        stack_we;
    logic [SP_W-1:0] stack_waddr;

    logic              dmem_we;
    logic [MEM_AW-1:0] dmem_waddr, dmem_raddr;
    logic [7:0]        dmem_wdata, dmem_rdata;
    logic              fb_we;
    logic [PIX_AW-1:0] fb_waddr, fb_raddr;
    logic [0:0]        fb_wdata, fb_rdata;

    logic [3:0]  x_f, y_f, n_f;
    logic [7:0]  kk_f;
    logic [11:0] nnn_f;
    logic [7:0]  per;
    logic [11:0] idx_addr;
    logic [7:0]  row_sum, col_sum;
    logic [PIX_AW-1:0] pos;
    logic [2:0]  bit_sel;
    logic        draw_adv;
    logic        draw_coll;
    logic [8:0]  add_sum;
    logic [7:0]  alu_x, alu_y;
    logic        skip;

    assign x_f   = op_reg[11:8];
    assign y_f   = op_reg[7:4];
    assign n_f   = op_reg[3:0];
    assign kk_f  = op_reg[7:0];
    assign nnn_f = op_reg[11:0];
    assign per   = (tick_reg == 8'd0) ? 8'd1 : tick_reg;
    assign idx_addr = index_reg[11:0] + {8'd0, cnt_reg[3:0]};
    assign row_sum  = vy_reg + {4'd0, cnt_reg[3:0]};
    assign col_sum  = vx_reg + {5'd0, p_reg};
    assign pos      = {row_sum[ROW_W-1:0], col_sum[COL_W-1:0]};
    assign bit_sel  = ~p_reg;
    assign gp_rd    = gp_regs[rd_sel];
    assign add_sum  = {1'b0, vx_reg} + {1'b0, vy_reg};
    // alu operands after the flag write, so VF as an operand reads the new flag
    assign alu_x    = (x_f == 4'hF) ? vf_wdata : vx_reg;
    assign alu_y    = (y_f == 4'hF) ? vf_wdata : vy_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    c8ie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
        .clk   (clk),
        .we    (dmem_we),
        .waddr (dmem_waddr),
        .wdata (dmem_wdata),
        .raddr (dmem_raddr),
        .rdata (dmem_rdata)
    );

    c8ie_ram #(.WIDTH(1), .DEPTH(PIXELS)) u_fbuf (
        .clk   (clk),
        .we    (fb_we),
        .waddr (fb_waddr),
        .wdata (fb_wdata),
        .raddr (fb_raddr),
        .rdata (fb_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            pc_reg        <= PC_RESET;
            index_reg     <= '0;
            sp_reg        <= '0;
            delay_reg     <= '0;
            sound_reg     <= '0;
            wait_reg      <= 5'h1F;
            accum_reg     <= '0;
            tick_reg      <= TICK_RESET;
            cnt_reg       <= '0;
            p_reg         <= '0;
            coll_reg      <= 1'b0;
            for (int i = 0; i < 16; i++)
            begin
                gp_regs[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
            index_reg     <= index_next;
            sp_reg        <= sp_next;
            delay_reg     <= delay_next;
            sound_reg     <= sound_next;
            wait_reg      <= wait_next;
            accum_reg     <= accum_next;
            cnt_reg       <= cnt_next;
            p_reg         <= p_next;
            coll_reg      <= coll_next;
            if (cfg_valid && cfg_ready)
            begin
                tick_reg <= cfg_data;
            end
            if (vf_we)
            begin
                gp_regs[15] <= vf_wdata;
            end
            if (gp_we)
            begin
                gp_regs[gp_waddr] <= gp_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        op_reg      <= op_next;
        keys_reg    <= keys_next;
        rnd_reg     <= rnd_next;
        maddr_reg   <= maddr_next;
        mdata_reg   <= mdata_next;
        elapsed_reg <= elapsed_next;
        pidx_reg    <= pidx_next;
        vx_reg      <= vx_next;
        vy_reg      <= vy_next;
        bits_reg    <= bits_next;
        pix_reg     <= pix_next;
        o_pc_reg    <= o_pc_next;
        o_idx_reg   <= o_idx_next;
        o_flag_reg  <= o_flag_next;
        o_dly_reg   <= o_dly_next;
        o_snd_reg   <= o_snd_next;
        o_wait_reg  <= o_wait_next;
        o_pix_reg   <= o_pix_next;
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= pc_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        o_pc_next   = o_pc_reg;
        o_idx_next  = o_idx_reg;
        o_flag_next = o_flag_reg;
        o_dly_next  = o_dly_reg;
        o_snd_next  = o_snd_reg;
        o_wait_next = o_wait_reg;
        o_pix_next  = o_pix_reg;
        func_next    = func_reg;
        op_next      = op_reg;
        keys_next    = keys_reg;
        rnd_next     = rnd_reg;
        maddr_next   = maddr_reg;
        mdata_next   = mdata_reg;
        elapsed_next = elapsed_reg;
        pidx_next    = pidx_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        pc_next    = pc_reg;
        index_next = index_reg;
        sp_next    = sp_reg;
        delay_next = delay_reg;
        sound_next = sound_reg;
        wait_next  = wait_reg;
        accum_next = accum_reg;
        cnt_next   = cnt_reg;
        p_next     = p_reg;
        bits_next  = bits_reg;
        coll_next  = coll_reg;
        pix_next   = pix_reg;
        gp_we      = 1'b0;
        gp_waddr   = x_f;
        gp_wdata   = 8'd0;
        vf_we      = 1'b0;
        vf_wdata   = 8'd0;
        rd_sel     = x_f;
        stack_we   = 1'b0;
        stack_waddr = sp_reg + 1'b1;
        dmem_we    = 1'b0;
        dmem_waddr = idx_addr;
        dmem_wdata = 8'd0;
        dmem_raddr = idx_addr;
        fb_we      = 1'b0;
        fb_waddr   = pos;
        fb_wdata   = 1'b0;
        fb_raddr   = pos;
        draw_adv   = 1'b0;
        draw_coll  = coll_reg;
        skip       = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                dmem_we    = 1'b1;
                dmem_waddr = cnt_reg;
                dmem_wdata = mem_init_byte(cnt_reg);
                fb_we      = !cnt_reg[MEM_AW-1];
                fb_waddr   = cnt_reg[PIX_AW-1:0];
                cnt_next   = cnt_reg + 1'b1;
                if (&cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next    = func;
                    op_next      = opcode;
                    keys_next    = key_state;
                    rnd_next     = random_byte;
                    maddr_next   = mem_addr;
                    mdata_next   = mem_data;
                    elapsed_next = elapsed_ms;
                    pidx_next    = pixel_index;
                    pix_next     = 1'b0;
                    state_next   = S_RDX;
                end
            end
            S_RDX:
            begin
                vx_next    = gp_rd;
                state_next = S_RDY;
            end
            S_RDY:
            begin
                rd_sel     = y_f;
                vy_next    = gp_rd;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (func_t'(func_reg))
                    FUNC_EXEC:
                    begin
                        unique case (op_reg[15:12])
                            4'h0:
                            begin
                                if (op_reg == OP_CLS)
                                begin
                                    cnt_next   = '0;
                                    state_next = S_CLS;
                                end
                                else if (op_reg == OP_RET && sp_reg != '0
                                         && sp_reg <= SP_W'(STACK_DEPTH))
                                begin
                                    pc_next = stack_mem[sp_reg];
                                    sp_next = sp_reg - 1'b1;
                                end
                            end
                            4'h1: pc_next = nnn_f;
                            4'h2:
                            begin
                                if (sp_reg < SP_W'(STACK_DEPTH))
                                begin
                                    sp_next  = sp_reg + 1'b1;
                                    stack_we = 1'b1;
                                    pc_next  = nnn_f;
                                end
                            end
                            4'h3: skip = (vx_reg == kk_f);
                            4'h4: skip = (vx_reg != kk_f);
                            4'h5: skip = (vx_reg == vy_reg);
                            4'h6:
                            begin
                                gp_we    = 1'b1;
                                gp_wdata = kk_f;
                            end
                            4'h7:
                            begin
                                gp_we    = 1'b1;
                                gp_wdata = vx_reg + kk_f;
                            end
                            4'h8:
                            begin
                                unique case (n_f)
                                    4'h0: begin gp_we = 1'b1; gp_wdata = vy_reg; end
                                    4'h1: begin gp_we = 1'b1; gp_wdata = vx_reg | vy_reg; end
                                    4'h2: begin gp_we = 1'b1; gp_wdata = vx_reg & vy_reg; end
                                    4'h3: begin gp_we = 1'b1; gp_wdata = vx_reg ^ vy_reg; end
                                    4'h4:
                                    begin
                                        vf_we = 1'b1; vf_wdata = {7'd0, add_sum[8]};
                                        gp_we = 1'b1; gp_wdata = alu_x + alu_y;
                                    end
                                    4'h5:
                                    begin
                                        vf_we = 1'b1; vf_wdata = {7'd0, vx_reg > vy_reg};
                                        gp_we = 1'b1; gp_wdata = alu_x - alu_y;
                                    end
                                    4'h6:
                                    begin
                                        vf_we = 1'b1; vf_wdata = {7'd0, vx_reg[0]};
                                        gp_we = 1'b1; gp_wdata = {1'b0, alu_x[7:1]};
                                    end
                                    4'h7:
                                    begin
                                        vf_we = 1'b1; vf_wdata = {7'd0, vy_reg > vx_reg};
                                        gp_we = 1'b1; gp_wdata = alu_y - alu_x;
                                    end
                                    4'hE:
                                    begin
                                        vf_we = 1'b1; vf_wdata = {7'd0, vx_reg[7]};
                                        gp_we = 1'b1; gp_wdata = {alu_x[6:0], 1'b0};
                                    end
                                    default: ;
                                endcase
                            end
                            4'h9: skip = (vx_reg != vy_reg);
                            4'hA: index_next = {4'd0, nnn_f};
                            4'hB: pc_next = nnn_f + {4'd0, gp_regs[0]};
                            4'hC:
                            begin
                                gp_we    = 1'b1;
                                gp_wdata = rnd_reg & kk_f;
                            end
                            4'hD:
                            begin
                                coll_next = 1'b0;
                                cnt_next  = '0;
                                if (n_f == 4'd0)
                                begin
                                    vf_we = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_DRW_MRD;
                                end
                            end
                            4'hE:
                            begin
                                if (kk_f == KK_SKP)
                                begin
                                    skip = keys_reg[vx_reg[3:0]];
                                end
                                else if (kk_f == KK_SKNP)
                                begin
                                    skip = !keys_reg[vx_reg[3:0]];
                                end
                            end
                            4'hF:
                            begin
                                cnt_next = '0;
                                priority case (kk_f)
                                    KK_GDLY: begin gp_we = 1'b1; gp_wdata = delay_reg; end
                                    KK_WKEY: wait_next  = {1'b0, x_f};
                                    KK_SDLY: delay_next = vx_reg;
                                    KK_SSND: sound_next = vx_reg;
                                    KK_ADDI: index_next = index_reg + {8'd0, vx_reg};
                                    KK_FONT: index_next = {4'd0, FONT_BASE}
                                                          + 16'(vx_reg[3:0]) * 16'd5;
                                    KK_BCD:  state_next = S_BCD;
                                    KK_STOR: state_next = S_STORE;
                                    KK_LOAD: state_next = S_LOAD_RD;
                                    default: ;
                                endcase
                            end
                        endcase
                        if (skip)
                        begin
                            pc_next = pc_reg + 12'd2;
                        end
                    end
                    FUNC_WMEM:
                    begin
                        dmem_we    = 1'b1;
                        dmem_waddr = maddr_reg;
                        dmem_wdata = mdata_reg;
                    end
                    FUNC_TIME:
                    begin
                        accum_next = accum_reg + {6'd0, elapsed_reg};
                        state_next = S_TICK;
                    end
                    FUNC_PIX:
                    begin
                        fb_raddr   = pidx_reg;
                        state_next = S_PIX;
                    end
                endcase
            end
            S_TICK:
            begin
                if (accum_reg > {8'd0, per})
                begin
                    accum_next = accum_reg - {8'd0, per};
                    if (delay_reg != 8'd0)
                    begin
                        delay_next = delay_reg - 1'b1;
                    end
                    if (sound_reg != 8'd0)
                    begin
                        sound_next = sound_reg - 1'b1;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PIX:
            begin
                pix_next   = fb_rdata[0];
                state_next = S_DONE;
            end
            S_CLS:
            begin
                fb_we    = 1'b1;
                fb_waddr = cnt_reg[PIX_AW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (&cnt_reg[PIX_AW-1:0])
                begin
                    state_next = S_DONE;
                end
            end
            S_BCD:
            begin
                dmem_we    = 1'b1;
                dmem_wdata = bcd_digit(vx_reg, cnt_reg[1:0]);
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'd2)
                begin
                    state_next = S_DONE;
                end
            end
            S_STORE:
            begin
                rd_sel     = cnt_reg[3:0];
                dmem_we    = 1'b1;
                dmem_wdata = gp_rd;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg[3:0] == x_f)
                begin
                    state_next = S_DONE;
                end
            end
            S_LOAD_RD:
            begin
                state_next = S_LOAD_WR;
            end
            S_LOAD_WR:
            begin
                gp_we    = 1'b1;
                gp_waddr = cnt_reg[3:0];
                gp_wdata = dmem_rdata;
                cnt_next = cnt_reg + 1'b1;
                state_next = (cnt_reg[3:0] == x_f) ? S_DONE : S_LOAD_RD;
            end
            S_DRW_MRD:
            begin
                state_next = S_DRW_MCAP;
            end
            S_DRW_MCAP:
            begin
                bits_next  = dmem_rdata;
                p_next     = '0;
                state_next = S_DRW_PRD;
            end
            S_DRW_PRD:
            begin
                if (bits_reg[bit_sel])
                begin
                    state_next = S_DRW_PWR;
                end
                else
                begin
                    draw_adv = 1'b1;
                end
            end
            S_DRW_PWR:
            begin
                fb_we     = 1'b1;
                fb_wdata  = ~fb_rdata;
                draw_coll = coll_reg | fb_rdata[0];
                coll_next = draw_coll;
                draw_adv  = 1'b1;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_pc_next   = pc_reg;
                    o_idx_next  = index_reg;
                    o_flag_next = gp_regs[15];
                    o_dly_next  = delay_reg;
                    o_snd_next  = (sound_reg != 8'd0);
                    o_wait_next = wait_reg;
                    o_pix_next  = pix_reg;
                    state_next  = S_IDLE;
                end
            end
        endcase

        // next pixel, next sprite row, or end of sprite
        if (draw_adv)
        begin
            if (p_reg == 3'd7)
            begin
                if (cnt_reg[3:0] == n_f - 4'd1)
                begin
                    vf_we      = 1'b1;
                    vf_wdata   = {7'd0, draw_coll};
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_DRW_MRD;
                end
            end
            else
            begin
                p_next     = p_reg + 1'b1;
                state_next = S_DRW_PRD;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_pc      = o_pc_reg;
    assign index_value  = o_idx_reg;
    assign flag_value   = o_flag_reg;
    assign delay_value  = o_dly_reg;
    assign sound_on     = o_snd_reg;
    assign key_wait_reg = o_wait_reg;
    assign pixel_value  = o_pix_reg;

    `C8IE_CHECK(a_sp_range, 1'b1, sp_reg <= SP_W'(STACK_DEPTH), "stack pointer past depth")
    `C8IE_CHECK_NEXT(a_accept_busy, in_valid && in_ready, state_reg == S_RDX, "accept not taken")
    `C8IE_CHECK(a_rose_from_done, $rose(out_valid_reg), $past(state_reg) == S_DONE,
                "result without finish")
    `C8IE_CHECK_NEXT(a_clear_no_accept, state_reg == S_CLEAR,
                     state_reg == S_CLEAR || state_reg == S_IDLE, "clear pass left early")

endmodule

`default_nettype wire

FILE: verif/chip8_instruction_executor_checker.sv
`default_nettype none

module chip8_instruction_executor_checker
    import c8ie_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [7:0]        cfg_data,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic [1:0]        func,
    input  wire logic [15:0]       opcode,
    input  wire logic [15:0]       key_state,
    input  wire logic [7:0]        random_byte,
    input  wire logic [11:0]       mem_addr,
    input  wire logic [7:0]        mem_data,
    input  wire logic [9:0]        elapsed_ms,
    input  wire logic [10:0]       pixel_index,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic [11:0]       next_pc,
    input  wire logic [15:0]       index_value,
    input  wire logic [7:0]        flag_value,
    input  wire logic [7:0]        delay_value,
    input  wire logic              sound_on,
    input  wire logic signed [4:0] key_wait_reg,
    input  wire logic              pixel_value,
    output int                     pending,
    output int                     errors
);

    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] idx;
        logic [7:0]  vf;
        logic [7:0]  dly;
        logic        snd;
        logic [4:0]  wk;
        logic        pix;
    } machine_view_t;

    machine_view_t view_q[$];

    logic [11:0] pc;
    logic [15:0] ireg;
    logic [7:0]  vreg [16];
    logic [11:0] stk [STACK_DEPTH + 1];
    int          sp;
    logic [7:0]  mem [MEM_BYTES];
    bit          fb [PIXELS];
    logic [7:0]  dly;
    logic [7:0]  snd;
    logic [4:0]  wk;
    int          accum;
    logic [7:0]  tick;

    function automatic int maddr(input int a);
        return a % MEM_BYTES;
    endfunction

    task automatic skip_on(input bit c);
        if (c)
        begin
            pc = pc + 12'd2;
        end
    endtask

    // flag goes first, then the result reads the registers, VF included
    task automatic exec_alu(input int x, input int y, input int n);
        logic [7:0] vx;
        logic [7:0] vy;
        vx = vreg[x];
        vy = vreg[y];
        case (n)
            0: vreg[x] = vy;
            1: vreg[x] = vx | vy;
            2: vreg[x] = vx & vy;
            3: vreg[x] = vx ^ vy;
            4:
            begin
                vreg[15] = {7'd0, (9'(vx) + 9'(vy) > 9'h0FF)};
                vreg[x] = vreg[x] + vreg[y];
            end
            5:
            begin
                vreg[15] = {7'd0, (vx > vy)};
                vreg[x] = vreg[x] - vreg[y];
            end
            6:
            begin
                vreg[15] = {7'd0, vx[0]};
                vreg[x] = vreg[x] >> 1;
            end
            7:
            begin
                vreg[15] = {7'd0, (vy > vx)};
                vreg[x] = vreg[y] - vreg[x];
            end
            14:
            begin
                vreg[15] = {7'd0, vx[7]};
                vreg[x] = vreg[x] << 1;
            end
            default: ;
        endcase
    endtask

    task automatic exec_draw(input int x, input int y, input int n);
        int vx;
        int vy;
        int row;
        int pos;
        logic [7:0] bits;
        vx = vreg[x];
        vy = vreg[y];
        vreg[15] = 8'd0;
        for (int m = 0; m < n; m++)
        begin
            bits = mem[maddr(int'(ireg) + m)];
            row = (vy + m) % SCREEN_H;
            for (int p = 0; p < 8; p++)
            begin
                pos = row * SCREEN_W + (vx + p) % SCREEN_W;
                if (bits[7 - p])
                begin
                    if (fb[pos])
                    begin
                        fb[pos] = 1'b0;
                        vreg[15] = 8'd1;
                    end
                    else
                    begin
                        fb[pos] = 1'b1;
                    end
                end
            end
        end
    endtask

    task automatic exec_misc(input int x, input logic [7:0] kk);
        logic [7:0] v;
        v = vreg[x];
        case (kk)
            KK_GDLY: vreg[x] = dly;
            KK_WKEY: wk = 5'(x);
            KK_SDLY: dly = v;
            KK_SSND: snd = v;
            KK_ADDI: ireg = ireg + 16'(v);
            KK_FONT: ireg = 16'(FONT_BASE) + 16'(v[3:0]) * 16'd5;
            KK_BCD:
            begin
                mem[maddr(int'(ireg))] = v / 8'd100;
                mem[maddr(int'(ireg) + 1)] = (v / 8'd10) % 8'd10;
                mem[maddr(int'(ireg) + 2)] = v % 8'd10;
            end
            KK_STOR:
                for (int k = 0; k <= x; k++)
                begin
                    mem[maddr(int'(ireg) + k)] = vreg[k];
                end
            KK_LOAD:
                for (int k = 0; k <= x; k++)
                begin
                    vreg[k] = mem[maddr(int'(ireg) + k)];
                end
            default: ;
        endcase
    endtask

    task automatic exec_opcode(input logic [15:0] op, input logic [15:0] keys,
                               input logic [7:0] rnd);
        int x;
        int y;
        x = op[11:8];
        y = op[7:4];
        case (op[15:12])
            4'h0:
                if (op == OP_CLS)
                begin
                    foreach (fb[i]) fb[i] = 1'b0;
                end
                else if (op == OP_RET && sp > 0)
                begin
                    pc = stk[sp];
                    sp--;
                end
            4'h1: pc = op[11:0];
            4'h2:
                if (sp < STACK_DEPTH)
                begin
                    sp++;
                    stk[sp] = pc;
                    pc = op[11:0];
                end
            4'h3: skip_on(vreg[x] == op[7:0]);
            4'h4: skip_on(vreg[x] != op[7:0]);
            4'h5: skip_on(vreg[x] == vreg[y]);
            4'h6: vreg[x] = op[7:0];
            4'h7: vreg[x] = vreg[x] + op[7:0];
            4'h8: exec_alu(x, y, op[3:0]);
            4'h9: skip_on(vreg[x] != vreg[y]);
            4'hA: ireg = {4'd0, op[11:0]};
            4'hB: pc = op[11:0] + 12'(vreg[0]);
            4'hC: vreg[x] = rnd & op[7:0];
            4'hD: exec_draw(x, y, op[3:0]);
            4'hE:
                if (op[7:0] == KK_SKP)
                begin
                    skip_on(keys[vreg[x][3:0]]);
                end
                else if (op[7:0] == KK_SKNP)
                begin
                    skip_on(!keys[vreg[x][3:0]]);
                end
            default: exec_misc(x, op[7:0]);
        endcase
    endtask

    task automatic elapse_time(input int ms);
        int per;
        per = (tick == 8'd0) ? 1 : int'(tick);
        accum = (accum + ms) & 16'hFFFF;
        while (accum > per)
        begin
            accum -= per;
            if (dly > 0) dly--;
            if (snd > 0) snd--;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        machine_view_t got;
        machine_view_t want;
        bit            pix;
        if (!rst_n)
        begin
            pc = PC_RESET;
            ireg = '0;
            foreach (vreg[i]) vreg[i] = '0;
            foreach (stk[i]) stk[i] = '0;
            sp = 0;
            foreach (mem[i]) mem[i] = '0;
            for (int i = 0; i < FONT_BYTES; i++) mem[int'(FONT_BASE) + i] = GLYPHS[i];
            foreach (fb[i]) fb[i] = 1'b0;
            dly = '0;
            snd = '0;
            wk = 5'h1F;
            accum = 0;
            tick = TICK_RESET;
            view_q.delete();
            pending = 0;
            errors = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tick = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                pix = 1'b0;
                case (func_t'(func))
                    FUNC_EXEC: exec_opcode(opcode, key_state, random_byte);
                    FUNC_WMEM: mem[mem_addr] = mem_data;
                    FUNC_TIME: elapse_time(elapsed_ms);
                    default:   pix = fb[pixel_index];
                endcase
                view_q.push_back('{pc, ireg, vreg[15], dly, snd != 0, wk, pix});
            end
            if (out_valid && out_ready)
            begin
                got = '{next_pc, index_value, flag_value, delay_value, sound_on,
                        key_wait_reg, pixel_value};
                if (view_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat: %p", got);
                end
                else
                begin
                    want = view_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            pending = view_q.size();
        end
    end

endmodule

`default_nettype wire

FILE: verif/chip8_instruction_executor_test.sv
`default_nettype none

module chip8_instruction_executor_test;
    import c8ie_pkg::*;

    localparam int CYCLE_LIMIT = 10_000_000;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [7:0]        cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        func;
    logic [15:0]       opcode;
    logic [15:0]       key_state;
    logic [7:0]        random_byte;
    logic [11:0]       mem_addr;
    logic [7:0]        mem_data;
    logic [9:0]        elapsed_ms;
    logic [10:0]       pixel_index;
    logic              out_valid;
    logic              out_ready;
    logic [11:0]       next_pc;
    logic [15:0]       index_value;
    logic [7:0]        flag_value;
    logic [7:0]        delay_value;
    logic              sound_on;
    logic signed [4:0] key_wait_reg;
    logic              pixel_value;

    int pending;
    int errors;
    int cycles;
    int stall_left;
    bit calm;

    chip8_instruction_executor u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .opcode(opcode), .key_state(key_state), .random_byte(random_byte),
        .mem_addr(mem_addr), .mem_data(mem_data), .elapsed_ms(elapsed_ms),
        .pixel_index(pixel_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .next_pc(next_pc), .index_value(index_value), .flag_value(flag_value),
        .delay_value(delay_value), .sound_on(sound_on), .key_wait_reg(key_wait_reg),
        .pixel_value(pixel_value)
    );

    chip8_instruction_executor_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .opcode(opcode), .key_state(key_state), .random_byte(random_byte),
        .mem_addr(mem_addr), .mem_data(mem_data), .elapsed_ms(elapsed_ms),
        .pixel_index(pixel_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .next_pc(next_pc), .index_value(index_value), .flag_value(flag_value),
        .delay_value(delay_value), .sound_on(sound_on), .key_wait_reg(key_wait_reg),
        .pixel_value(pixel_value),
        .pending(pending), .errors(errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (calm || !rst_n)
        begin
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_beat(input func_t f, input logic [15:0] op,
                             input logic [11:0] addr, input logic [7:0] dat,
                             input logic [9:0] ms);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        opcode <= op;
        key_state <= 16'($urandom);
        random_byte <= 8'($urandom);
        mem_addr <= addr;
        mem_data <= dat;
        elapsed_ms <= ms;
        pixel_index <= 11'($urandom);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic exec_op(input logic [15:0] op);
        send_beat(FUNC_EXEC, op, 12'($urandom), 8'($urandom), 10'($urandom));
    endtask

    task automatic write_tick(input logic [7:0] period);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= period;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_opcode();
        logic [15:0] op;
        logic [7:0]  misc_kk [9] = '{KK_GDLY, KK_WKEY, KK_SDLY, KK_SSND, KK_ADDI,
                                     KK_FONT, KK_BCD, KK_STOR, KK_LOAD};
        logic [3:0]  alu_n [9] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE};
        op = 16'($urandom);
        case ($urandom_range(0, 19))
            0: op = ($urandom_range(0, 7) == 0) ? OP_CLS : OP_RET;
            1, 2: op[15:12] = 4'h2;
            3, 4: op = OP_RET;
            5, 6: op[15:12] = 4'h6;
            7, 8, 9: op = {4'h8, op[11:4], alu_n[$urandom_range(0, 8)]};
            10, 11: op = {4'hF, op[11:8], misc_kk[$urandom_range(0, 8)]};
            12, 13: op = {4'hD, op[11:4], 4'($urandom_range(0, 6))};
            14: op = {4'hE, op[11:8], ($urandom_range(0, 1) != 0) ? KK_SKP : KK_SKNP};
            15: op[15:12] = 4'($urandom_range(3, 5));
            16: op[15:12] = 4'($urandom_range(9, 12));
            17: op[15:12] = 4'h7;
            default:
                if (op[15:12] == 4'hD && op[3:0] > 4'h8)
                    op[3:0] = 4'h8;
                else if (op == OP_CLS)
                    op = 16'h0000;
        endcase
        return op;
    endfunction

    task automatic random_phase(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                exec_op(pick_opcode());
            else if (r == 7)
                send_beat(FUNC_WMEM, 16'($urandom), 12'($urandom), 8'($urandom),
                          10'($urandom));
            else if (r == 8)
                send_beat(FUNC_TIME, 16'($urandom), 12'($urandom), 8'($urandom),
                          10'($urandom));
            else
                send_beat(FUNC_PIX, 16'($urandom), 12'($urandom), 8'($urandom),
                          10'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cycles = 0;
        stall_left = 0;
        calm = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        func = '0;
        opcode = '0;
        key_state = '0;
        random_byte = '0;
        mem_addr = '0;
        mem_data = '0;
        elapsed_ms = '0;
        pixel_index = '0;
        out_ready = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: flags, skips, stack ends, memory ops, sprites with wrap
        exec_op(16'h60FF);
        exec_op(16'h6101);
        exec_op(16'h8014);
        exec_op(16'h8015);
        exec_op(16'h8017);
        exec_op(16'h801E);
        exec_op(16'h8016);
        exec_op(16'h6FFF);
        exec_op(16'h8FF4);
        exec_op(OP_RET);
        exec_op(16'h3000);
        exec_op(16'h4001);
        exec_op(16'h5010);
        exec_op(16'h9010);
        exec_op(16'h603F);
        exec_op(16'h611E);
        exec_op(16'hF029);
        exec_op(16'hD01F);
        exec_op(16'hD01F);
        exec_op(16'hAFFE);
        exec_op(16'hF033);
        exec_op(16'hFF55);
        exec_op(16'hFF65);
        exec_op(16'hF01E);
        exec_op(16'hE09E);
        exec_op(16'hE0A1);
        exec_op(16'hC0FF);
        exec_op(16'hB123);
        exec_op(16'hFF0A);
        exec_op(16'h60FF);
        exec_op(16'hF015);
        exec_op(16'hF018);
        send_beat(FUNC_TIME, 16'h0, 12'h0, 8'h0, 10'h3FF);
        exec_op(16'hF107);
        exec_op(16'h0123);
        send_beat(FUNC_WMEM, 16'h0, 12'hFFF, 8'hFF, 10'h0);
        send_beat(FUNC_PIX, 16'h0, 12'h0, 8'h0, 10'h0);
        exec_op(OP_CLS);
        for (int i = 0; i < STACK_DEPTH + 1; i++) exec_op(16'h2000 | 16'($urandom_range(0, 4095)));
        for (int i = 0; i < STACK_DEPTH + 1; i++) exec_op(OP_RET);
        exec_op(16'h1FFF);

        write_tick(8'd1);
        random_phase(200);
        write_tick(8'd255);
        random_phase(200);
        write_tick(8'd0);
        random_phase(180);
        write_tick(8'($urandom_range(2, 254)));
        random_phase(100);
        calm = 1'b1;
        random_phase(100);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: chip8_instruction_executor.f
+incdir+rtl
rtl/c8ie_pkg.sv
rtl/c8ie_ram.sv
rtl/chip8_instruction_executor.sv
verif/chip8_instruction_executor_checker.sv
verif/chip8_instruction_executor_test.sv
